/* sv/ssq_pkg.sv */
// Shared types, command codes and sizes of the sorted sleep queue.
`timescale 1ns / 1ps

package ssq_pkg;

  localparam int ID_W            = 4;
  localparam int WAKE_W          = 64;
  localparam int CNT_OUT_W       = 5;
  localparam int ID_NUM          = 1 << ID_W;
  localparam int DEF_MAX_STRANDS = 16;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [ID_W-1:0]   strand_id;
    logic [WAKE_W-1:0] wake_time;
  } ssq_req_t;

  typedef struct packed {
    logic [WAKE_W-1:0]    earliest_wake;
    logic                 queue_empty;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 error;
  } ssq_rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic exec;
  } ssq_cmd_t;

endpackage

/* sv/ssq_ctrl.sv */
// Controller state machine of the sorted sleep queue.
`timescale 1ns / 1ps

module ssq_ctrl
  import ssq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  output ssq_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == ST_EXEC);
    end
  end

  assign cmd.load  = (state_r == ST_IDLE) && start;
  assign cmd.exec  = (state_r == ST_EXEC);
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* sv/ssq_datapath.sv */
// Sorted shift array of sleeping tasks with its id marks and count.
`timescale 1ns / 1ps

module ssq_datapath
  import ssq_pkg::*;
#(
  parameter int MAX_STRANDS = DEF_MAX_STRANDS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  ssq_cmd_t cmd,
  input  ssq_req_t in_req,
  output ssq_rsp_t out_rsp
);

  localparam int IDX_W = $clog2(MAX_STRANDS);
  localparam int CNT_W = $clog2(MAX_STRANDS + 1);

  ssq_req_t          req_r;
  logic [ID_W-1:0]   slot_id_r   [MAX_STRANDS];
  logic [WAKE_W-1:0] slot_wake_r [MAX_STRANDS];
  logic [ID_W-1:0]   slot_id_nxt [MAX_STRANDS];
  logic [WAKE_W-1:0] slot_wake_nxt [MAX_STRANDS];
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [ID_NUM-1:0] marks_r, marks_nxt;
  logic              error_r;

  logic [MAX_STRANDS-1:0] le;
  logic [MAX_STRANDS-1:0] match;
  logic [IDX_W-1:0]       rem_pos;
  logic                   id_ok;
  logic                   queued;
  logic                   full;
  logic                   is_ins;
  logic                   is_rem;
  logic                   do_ins;
  logic                   do_rem;
  logic                   dup;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
    end
  end

  assign id_ok  = (int'(req_r.strand_id) < MAX_STRANDS);
  assign queued = marks_r[req_r.strand_id];
  assign full   = (count_r == CNT_W'(MAX_STRANDS));
  assign is_ins = (req_r.command == CMD_INSERT);
  assign is_rem = (req_r.command == CMD_REMOVE);
  assign dup    = is_ins && id_ok && queued;
  assign do_ins = cmd.exec && is_ins && id_ok && !queued && !full;
  assign do_rem = cmd.exec && is_rem && id_ok && queued;

  // Per-slot compares; the valid slots form a prefix, so le is a prefix too.
  always_comb begin
    for (int k = 0; k < MAX_STRANDS; k++) begin
      le[k]    = (CNT_W'(k) < count_r) && (slot_wake_r[k] <= req_r.wake_time);
      match[k] = (CNT_W'(k) < count_r) && (slot_id_r[k] == req_r.strand_id);
    end
  end

  // At most one slot matches, so OR-ing the indices encodes its position.
  always_comb begin
    rem_pos = '0;
    for (int k = 0; k < MAX_STRANDS; k++) begin
      if (match[k]) begin
        rem_pos = rem_pos | IDX_W'(k);
      end
    end
  end

  for (genvar k = 0; k < MAX_STRANDS; k++) begin : g_slot
    logic [ID_W-1:0]   prev_id;
    logic [WAKE_W-1:0] prev_wake;
    logic              prev_le;
    logic [ID_W-1:0]   next_id;
    logic [WAKE_W-1:0] next_wake;
    logic              take_new;
    logic              take_prev;
    logic              take_next;

    if (k == 0) begin : g_first
      assign prev_id   = req_r.strand_id;
      assign prev_wake = req_r.wake_time;
      assign prev_le   = 1'b1;
    end else begin : g_inner
      assign prev_id   = slot_id_r[k-1];
      assign prev_wake = slot_wake_r[k-1];
      assign prev_le   = le[k-1];
    end

    if (k == MAX_STRANDS - 1) begin : g_last
      assign next_id   = slot_id_r[k];
      assign next_wake = slot_wake_r[k];
    end else begin : g_body
      assign next_id   = slot_id_r[k+1];
      assign next_wake = slot_wake_r[k+1];
    end

    // Insert: keep earlier-or-equal slots, place the new entry, push the rest up.
    assign take_new  = do_ins && !le[k] && prev_le;
    assign take_prev = do_ins && !le[k] && !prev_le;
    // Remove: close the gap from the removed slot upwards.
    assign take_next = do_rem && (IDX_W'(k) >= rem_pos);

    assign slot_id_nxt[k]   = take_new  ? req_r.strand_id :
                              take_prev ? prev_id :
                              take_next ? next_id : slot_id_r[k];
    assign slot_wake_nxt[k] = take_new  ? req_r.wake_time :
                              take_prev ? prev_wake :
                              take_next ? next_wake : slot_wake_r[k];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_STRANDS; k++) begin
      slot_id_r[k]   <= slot_id_nxt[k];
      slot_wake_r[k] <= slot_wake_nxt[k];
    end
  end

  always_comb begin
    count_nxt = count_r;
    marks_nxt = marks_r;
    if (do_ins) begin
      count_nxt                  = count_r + CNT_W'(1);
      marks_nxt[req_r.strand_id] = 1'b1;
    end else if (do_rem) begin
      count_nxt                  = count_r - CNT_W'(1);
      marks_nxt[req_r.strand_id] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      marks_r <= '0;
      error_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      marks_r <= marks_nxt;
      if (cmd.exec) begin
        error_r <= dup;
      end
    end
  end

  assign out_rsp.earliest_wake = (count_r != '0) ? slot_wake_r[0] : '1;
  assign out_rsp.queue_empty   = (count_r == '0);
  assign out_rsp.entry_count   = CNT_OUT_W'(count_r);
  assign out_rsp.error         = error_r;

endmodule

/* sv/sorted_sleep_queue_unit.sv */
// Top level of the sorted sleep queue: controller and shift-array datapath.
`timescale 1ns / 1ps

// Sorted sleep queue. A request is taken when start is high and busy is low;
// the accepting edge registers it and the execute state then updates the
// sorted shift array in one step (all slots compare against the request in
// parallel and move by at most one place). Busy is high in the execute state
// only. The result follows on out_rsp with out_valid high
// for exactly one cycle, in the same cycle in which the next request may be
// taken; the receiver cannot stall, so it must take the result then. The
// result shows the head wake time (all ones when empty), the empty flag, the
// entry count and an error flag for an insert of an id already queued.

module sorted_sleep_queue_unit
  import ssq_pkg::*;
#(
  parameter int MAX_STRANDS = DEF_MAX_STRANDS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ssq_req_t in_req,
  output logic     out_valid,
  output ssq_rsp_t out_rsp
);

  ssq_cmd_t cmd;

  ssq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ssq_datapath #(
    .MAX_STRANDS (MAX_STRANDS)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

endmodule

/* sv/ssq_checker.sv */
// Port-level assertions of the sorted sleep queue and their bind.
`timescale 1ns / 1ps

module ssq_checker
  import ssq_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_valid,
  input ssq_rsp_t out_rsp
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after an accepted request");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("no result two cycles after an accepted request");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.queue_empty == (out_rsp.entry_count == '0)))
    else $error("empty flag disagrees with entry count");

  a_empty_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.queue_empty) |-> (out_rsp.earliest_wake == '1))
    else $error("empty queue reports a head wake time");

endmodule

bind sorted_sleep_queue_unit ssq_checker u_ssq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
